### src/cjt_pkg.sv
// ----------------------------------------------------------------------------
// cjt_pkg
// Shared types and constants of the cubic joint trajectory generator.
// ----------------------------------------------------------------------------
package cjt_pkg;

	localparam int ANG_W   = 24;  // Q3.20 angle
	localparam int JNT_W   = 3;
	localparam int IDX_W   = 6;
	localparam int CNT_W   = 7;   // step count register
	localparam int DEN_W   = 22;  // largest denominator is 2^21
	localparam int D_W     = DEN_W + 1;  // doubled denominator
	localparam int REM_W   = 51;  // dividend magnitude
	localparam int QUO_W   = 28;  // quotient magnitude bits
	localparam int MAX_STEPS_DEF = 64;
	localparam logic [CNT_W-1:0] STEPS_RST = CNT_W'(64);

	localparam logic MODE_TWO_POINT = 1'b0;
	localparam logic MODE_VIA       = 1'b1;

	// Sideband that rides along with a sample through the pipeline.
	typedef struct packed {
		logic [JNT_W-1:0] joint;
		logic [IDX_W-1:0] idx;
		logic             last;
	} tag_t;

	// One sample issued by the sequencer.
	typedef struct packed {
		logic                    mode;
		logic                    seg;
		logic [IDX_W-1:0]        j;
		logic [CNT_W-1:0]        t;
		logic [CNT_W-1:0]        s;
		logic signed [ANG_W-1:0] a0;
		logic signed [ANG_W-1:0] am;
		logic signed [ANG_W-1:0] a1;
		tag_t                    tag;
	} samp_t;

endpackage

### src/cubic_joint_trajectory.sv
// Throughput: one sample per cycle while a move is active; a command occupies
// the sequencer for its sample count (2 to 64 samples), and the next command
// is taken on the edge that issues the previous command's last sample.
// The poly stages, the 28-stage quotient pipeline and the output register set
// the latency. Results cannot be stalled.
// Reset clears all valid bits and the sequencer and sets the step count to 64.
// ----------------------------------------------------------------------------
// cubic_joint_trajectory
// Cubic joint move interpolator with two-point and via modes, Q3.20 angles.
// ----------------------------------------------------------------------------
module cubic_joint_trajectory #(
	parameter int MAX_STEPS = cjt_pkg::MAX_STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cjt_pkg::CNT_W-1:0]        cfg_wdata,
	input  logic                             start,
	output logic                             busy,
	input  logic                             action,
	input  logic [cjt_pkg::JNT_W-1:0]        joint,
	input  logic signed [cjt_pkg::ANG_W-1:0] start_angle,
	input  logic signed [cjt_pkg::ANG_W-1:0] via_angle,
	input  logic signed [cjt_pkg::ANG_W-1:0] end_angle,
	output logic                             sample_valid,
	output logic [cjt_pkg::JNT_W-1:0]        joint_out,
	output logic [cjt_pkg::IDX_W-1:0]        sample_index,
	output logic signed [cjt_pkg::ANG_W-1:0] sample_angle,
	output logic                             last
);
	import cjt_pkg::*;

	logic [CNT_W-1:0] steps_q;

	// Step count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= STEPS_RST;
		end else if (cfg_we) begin
			steps_q <= cfg_wdata;
		end
	end

	logic  samp_valid;
	samp_t samp;

	cjt_seq #(.MAX_STEPS(MAX_STEPS)) u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .steps(steps_q),
		.action(action), .joint(joint), .start_angle(start_angle),
		.via_angle(via_angle), .end_angle(end_angle),
		.samp_valid(samp_valid), .samp(samp)
	);

	logic                    pv;
	logic [REM_W-1:0]        p_rem;
	logic [D_W-1:0]          p_den2;
	logic                    p_neg;
	logic signed [ANG_W-1:0] p_base;
	tag_t                    p_tag;

	cjt_poly u_poly (
		.clk(clk), .arst_n(arst_n), .in_valid(samp_valid), .samp(samp),
		.out_valid(pv), .rem(p_rem), .den2(p_den2), .neg(p_neg),
		.base(p_base), .tag(p_tag)
	);

	logic                    dv;
	logic [QUO_W-1:0]        d_quo;
	logic                    d_neg;
	logic signed [ANG_W-1:0] d_base;
	tag_t                    d_tag;

	cjt_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(pv), .rem(p_rem), .den2(p_den2),
		.neg(p_neg), .base(p_base), .tag(p_tag),
		.out_valid(dv), .quo(d_quo), .quo_neg(d_neg), .quo_base(d_base),
		.quo_tag(d_tag)
	);

	// Apply sign, add the segment start and saturate.
	logic signed [QUO_W:0]   qs_c;
	logic signed [QUO_W+1:0] r_c;
	logic signed [ANG_W-1:0] sat_c;

	always_comb begin
		qs_c = d_neg ? -$signed({1'b0, d_quo}) : $signed({1'b0, d_quo});
		r_c  = (QUO_W+2)'(d_base) + (QUO_W+2)'(qs_c);
		if (r_c < -$signed((QUO_W+2)'(1) <<< (ANG_W-1))) begin
			sat_c = {1'b1, {(ANG_W-1){1'b0}}};
		end else if (r_c > $signed(((QUO_W+2)'(1) <<< (ANG_W-1)) - (QUO_W+2)'(1))) begin
			sat_c = {1'b0, {(ANG_W-1){1'b1}}};
		end else begin
			sat_c = ANG_W'(r_c);
		end
	end

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= dv;
		end
	end

	logic [JNT_W-1:0]        joint_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [ANG_W-1:0] angle_q;
	logic                    last_q;

	always_ff @(posedge clk) begin
		joint_q <= d_tag.joint;
		idx_q   <= d_tag.idx;
		angle_q <= sat_c;
		last_q  <= d_tag.last;
	end

	assign sample_valid = valid_q;
	assign joint_out    = joint_q;
	assign sample_index = idx_q;
	assign sample_angle = angle_q;
	assign last         = valid_q && last_q;

`ifndef ASSERT_OFF
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> sample_valid)
		else $error("last flag without a valid sample");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !last |=> sample_valid &&
			sample_index == IDX_W'($past(sample_index) + IDX_W'(1)))
		else $error("samples of one move are not consecutive");

	a_move_first: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && last |=> !sample_valid || sample_index == '0)
		else $error("a new move does not start at sample zero");
`endif

endmodule

### src/cjt_seq.sv
// ----------------------------------------------------------------------------
// cjt_seq
// Takes one move command and issues its samples, one per cycle.
// ----------------------------------------------------------------------------
module cjt_seq #(
	parameter int MAX_STEPS = cjt_pkg::MAX_STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [cjt_pkg::CNT_W-1:0]        steps,
	input  logic                             action,
	input  logic [cjt_pkg::JNT_W-1:0]        joint,
	input  logic signed [cjt_pkg::ANG_W-1:0] start_angle,
	input  logic signed [cjt_pkg::ANG_W-1:0] via_angle,
	input  logic signed [cjt_pkg::ANG_W-1:0] end_angle,
	output logic                             samp_valid,
	output cjt_pkg::samp_t                   samp
);
	import cjt_pkg::*;

	logic                    active_q;
	logic                    mode_q;
	logic                    seg_q;
	logic [IDX_W-1:0]        j_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        nlast_q;
	logic [CNT_W-1:0]        t_q;
	logic [CNT_W-1:0]        s_q;
	logic [JNT_W-1:0]        joint_q;
	logic signed [ANG_W-1:0] a0_q;
	logic signed [ANG_W-1:0] am_q;
	logic signed [ANG_W-1:0] a1_q;

	logic             last_now;
	logic             accept;
	logic [CNT_W-1:0] s_eff;
	logic [CNT_W-1:0] t_eff;
	logic [CNT_W-1:0] n_eff;

	// Clamp the step count and size the segments.
	always_comb begin
		if (steps < CNT_W'(2)) begin
			s_eff = CNT_W'(2);
		end else if (steps > CNT_W'(MAX_STEPS)) begin
			s_eff = CNT_W'(MAX_STEPS);
		end else begin
			s_eff = steps;
		end
		t_eff = (action == MODE_VIA) ? (s_eff >> 1) : s_eff;
		n_eff = (action == MODE_VIA) ? CNT_W'(t_eff << 1) : s_eff;
	end

	assign last_now = active_q && (idx_q == nlast_q);
	assign busy     = active_q && !last_now;
	assign accept   = start && !busy;

	// Command latch and sample counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (accept) begin
			active_q <= 1'b1;
		end else if (last_now) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= action;
			joint_q <= joint;
			a0_q    <= start_angle;
			am_q    <= via_angle;
			a1_q    <= end_angle;
			s_q     <= s_eff;
			t_q     <= t_eff;
			nlast_q <= IDX_W'(n_eff - CNT_W'(1));
			j_q     <= '0;
			seg_q   <= 1'b0;
			idx_q   <= '0;
		end else if (active_q) begin
			idx_q <= idx_q + IDX_W'(1);
			if (CNT_W'(j_q) == t_q - CNT_W'(1)) begin
				j_q   <= '0;
				seg_q <= 1'b1;
			end else begin
				j_q <= j_q + IDX_W'(1);
			end
		end
	end

	assign samp_valid    = active_q;
	assign samp.mode     = mode_q;
	assign samp.seg      = seg_q;
	assign samp.j        = j_q;
	assign samp.t        = t_q;
	assign samp.s        = s_q;
	assign samp.a0       = a0_q;
	assign samp.am       = am_q;
	assign samp.a1       = a1_q;
	assign samp.tag.joint = joint_q;
	assign samp.tag.idx  = idx_q;
	assign samp.tag.last = last_now;

endmodule

### src/cjt_poly.sv
// ----------------------------------------------------------------------------
// cjt_poly
// Six pipeline stages that form the rounding dividend and divisor of a sample.
// ----------------------------------------------------------------------------
module cjt_poly (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  cjt_pkg::samp_t                   samp,
	output logic                             out_valid,
	output logic [cjt_pkg::REM_W-1:0]        rem,
	output logic [cjt_pkg::D_W-1:0]          den2,
	output logic                             neg,
	output logic signed [cjt_pkg::ANG_W-1:0] base,
	output cjt_pkg::tag_t                    tag
);
	import cjt_pkg::*;

	localparam int N2_W = 57;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Stage 1: squares, differences and segment end points.
	logic [11:0]             j2_s1;
	logic [6:0]              tj_s1;
	logic [8:0]              k_s1;
	logic [12:0]             jtj_s1;
	logic [12:0]             tt_s1;
	logic [CNT_W-1:0]        t_s1, s_s1;
	logic                    mode_s1, seg_s1;
	logic signed [ANG_W:0]   e_s1, d_s1;
	logic signed [ANG_W-1:0] a_s1;
	tag_t                    tag_s1;

	logic signed [ANG_W-1:0] seg_a, seg_b;
	logic [6:0]              tj_c;

	always_comb begin
		seg_a = samp.seg ? samp.am : samp.a0;
		seg_b = samp.seg ? samp.a1 : ((samp.mode == MODE_VIA) ? samp.am : samp.a1);
		tj_c  = samp.t - 7'(samp.j);
	end

	always_ff @(posedge clk) begin
		j2_s1   <= 12'(samp.j * samp.j);
		tj_s1   <= tj_c;
		k_s1    <= 9'(9'(3) * 9'(samp.t) - 9'(2) * 9'(samp.j));
		jtj_s1  <= 13'(samp.j * tj_c);
		tt_s1   <= 13'(samp.t * samp.t);
		t_s1    <= samp.t;
		s_s1    <= samp.s;
		mode_s1 <= samp.mode;
		seg_s1  <= samp.seg;
		e_s1    <= (ANG_W+1)'(seg_b) - (ANG_W+1)'(seg_a);
		d_s1    <= (ANG_W+1)'(samp.a1) - (ANG_W+1)'(samp.a0);
		a_s1    <= seg_a;
		tag_s1  <= samp.tag;
	end

	// Stage 2: shape polynomials and cube of the segment length.
	logic [20:0]             p_s2;
	logic signed [20:0]      q_s2;
	logic [19:0]             ttt_s2;
	logic [CNT_W-1:0]        t_s2, s_s2;
	logic                    mode_s2;
	logic signed [ANG_W:0]   e_s2, d_s2;
	logic signed [ANG_W-1:0] a_s2;
	tag_t                    tag_s2;

	logic [19:0] qpos, qneg;

	always_comb begin
		qpos = 20'(jtj_s1 * tj_s1);
		qneg = 20'(j2_s1 * tj_s1);
	end

	always_ff @(posedge clk) begin
		p_s2    <= 21'(j2_s1 * k_s1);
		q_s2    <= seg_s1 ? $signed({1'b0, qpos}) : -$signed({1'b0, qneg});
		ttt_s2  <= 20'(tt_s1 * t_s1);
		t_s2    <= t_s1;
		s_s2    <= s_s1;
		mode_s2 <= mode_s1;
		e_s2    <= e_s1;
		d_s2    <= d_s1;
		a_s2    <= a_s1;
		tag_s2  <= tag_s1;
	end

	// Stage 3: in via mode scale by step count and segment length; form the denominator.
	logic [27:0]             ps_s3;
	logic signed [27:0]      qt_s3;
	logic [DEN_W-1:0]        den_s3;
	logic signed [ANG_W:0]   e_s3, d_s3;
	logic signed [ANG_W-1:0] a_s3;
	tag_t                    tag_s3;

	always_ff @(posedge clk) begin
		ps_s3  <= (mode_s2 == MODE_VIA) ? 28'(p_s2 * s_s2) : 28'(p_s2);
		qt_s3  <= (mode_s2 == MODE_VIA) ? 28'(q_s2 * $signed({1'b0, t_s2})) : '0;
		den_s3 <= (mode_s2 == MODE_VIA) ? DEN_W'(ttt_s2 * s_s2) : DEN_W'(ttt_s2);
		e_s3   <= e_s2;
		d_s3   <= d_s2;
		a_s3   <= a_s2;
		tag_s3 <= tag_s2;
	end

	// Stage 4: the two angle products.
	logic signed [53:0]      m1_s4, m2_s4;
	logic [DEN_W-1:0]        den_s4;
	logic signed [ANG_W-1:0] a_s4;
	tag_t                    tag_s4;

	always_ff @(posedge clk) begin
		m1_s4  <= 54'(e_s3 * $signed({1'b0, ps_s3}));
		m2_s4  <= 54'(d_s3 * qt_s3);
		den_s4 <= den_s3;
		a_s4   <= a_s3;
		tag_s4 <= tag_s3;
	end

	// Stage 5: numerator plus half a divisor for round to nearest.
	logic signed [N2_W-1:0]  n2_s5;
	logic [DEN_W-1:0]        den_s5;
	logic signed [ANG_W-1:0] a_s5;
	tag_t                    tag_s5;

	logic signed [N2_W-1:0] num_c;

	assign num_c = N2_W'(m1_s4) + N2_W'(m2_s4);

	always_ff @(posedge clk) begin
		n2_s5  <= (num_c <<< 1) + $signed(N2_W'(den_s4));
		den_s5 <= den_s4;
		a_s5   <= a_s4;
		tag_s5 <= tag_s4;
	end

	// Stage 6: magnitude for a floor division of either sign.
	logic [REM_W-1:0]        rem_s6;
	logic [D_W-1:0]          den2_s6;
	logic                    neg_s6;
	logic signed [ANG_W-1:0] a_s6;
	tag_t                    tag_s6;

	logic [D_W-1:0]         dd_c;
	logic signed [N2_W-1:0] mneg_c;

	always_comb begin
		dd_c   = {den_s5, 1'b0};
		mneg_c = -n2_s5 + $signed(N2_W'(dd_c)) - $signed(N2_W'(1));
	end

	always_ff @(posedge clk) begin
		neg_s6  <= n2_s5[N2_W-1];
		rem_s6  <= n2_s5[N2_W-1] ? REM_W'(mneg_c) : REM_W'(n2_s5);
		den2_s6 <= dd_c;
		a_s6    <= a_s5;
		tag_s6  <= tag_s5;
	end

	// Valid bits of the six stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign out_valid = v_s6;
	assign rem       = rem_s6;
	assign den2      = den2_s6;
	assign neg       = neg_s6;
	assign base      = a_s6;
	assign tag       = tag_s6;

endmodule

### src/cjt_div.sv
// ----------------------------------------------------------------------------
// cjt_div
// Pipelined restoring divider, one quotient bit per stage, sideband carried.
// ----------------------------------------------------------------------------
module cjt_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [cjt_pkg::REM_W-1:0]        rem,
	input  logic [cjt_pkg::D_W-1:0]          den2,
	input  logic                             neg,
	input  logic signed [cjt_pkg::ANG_W-1:0] base,
	input  cjt_pkg::tag_t                    tag,
	output logic                             out_valid,
	output logic [cjt_pkg::QUO_W-1:0]        quo,
	output logic                             quo_neg,
	output logic signed [cjt_pkg::ANG_W-1:0] quo_base,
	output cjt_pkg::tag_t                    quo_tag
);
	import cjt_pkg::*;

	logic                    v_s   [QUO_W+1];
	logic [REM_W-1:0]        rem_s [QUO_W+1];
	logic [D_W-1:0]          d_s   [QUO_W+1];
	logic [QUO_W-1:0]        quo_s [QUO_W+1];
	logic                    neg_s [QUO_W+1];
	logic signed [ANG_W-1:0] a_s   [QUO_W+1];
	tag_t                    tag_s [QUO_W+1];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = rem;
	assign d_s[0]   = den2;
	assign quo_s[0] = '0;
	assign neg_s[0] = neg;
	assign a_s[0]   = base;
	assign tag_s[0] = tag;

	for (genvar g = 0; g < QUO_W; g++) begin : g_stage
		localparam int BP = QUO_W - 1 - g;

		logic [REM_W-1:0] dsh;
		logic             fits;

		// Trial subtract of the shifted divisor.
		always_comb begin
			dsh  = REM_W'(d_s[g]) << BP;
			fits = (rem_s[g] >= dsh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= fits ? (rem_s[g] - dsh) : rem_s[g];
			quo_s[g+1] <= {quo_s[g][QUO_W-2:0], fits};
			d_s[g+1]   <= d_s[g];
			neg_s[g+1] <= neg_s[g];
			a_s[g+1]   <= a_s[g];
			tag_s[g+1] <= tag_s[g];
		end
	end

	assign out_valid = v_s[QUO_W];
	assign quo       = quo_s[QUO_W];
	assign quo_neg   = neg_s[QUO_W];
	assign quo_base  = a_s[QUO_W];
	assign quo_tag   = tag_s[QUO_W];

endmodule

### tb/tb_cubic_joint_trajectory.sv
// ----------------------------------------------------------------------------
// tb_cubic_joint_trajectory
// Self-checking testbench for the cubic joint trajectory generator. Move
// commands are driven through the start/busy handshake, and every sample is
// compared against a cycle-free model of the cubic interpolation. The step
// count register is set to selected values of its legal range, its extremes and
// values out of range.
// ----------------------------------------------------------------------------
module tb_cubic_joint_trajectory;
	timeunit 1ns;
	timeprecision 1ps;

	import cjt_pkg::*;

	localparam int SETTLE_CYCLES = 48;    // covers the sample latency
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_MOVES = 450;
	localparam logic signed [ANG_W-1:0] ANG_LO = -24'sd8388608;
	localparam logic signed [ANG_W-1:0] ANG_HI = 24'sd8388607;

	// One expected trajectory sample.
	typedef struct {
		logic [JNT_W-1:0]        joint;
		logic [IDX_W-1:0]        idx;
		logic signed [ANG_W-1:0] angle;
		logic                    last;
	} sample_t;

	// Trajectory model and store of expected samples.
	class trajectory_board;
		sample_t          pending_q[$];
		logic [CNT_W-1:0] steps;
		int               n_moves;
		int               n_samples;
		int               n_errors;

		function void reset_state();
			steps = STEPS_RST;
			pending_q.delete();
		endfunction

		// Floor division for a positive divisor.
		function longint floor_quot(longint n, longint d);
			longint q;
			q = n / d;
			if ((n % d) != 0 && n < 0)
				q = q - 1;
			return q;
		endfunction

		// Segment start plus the rounded offset, saturated to Q3.20.
		function logic signed [ANG_W-1:0] round_angle(longint a, longint num, longint den);
			longint r;
			r = a + floor_quot(2 * num + den, 2 * den);
			if (r < longint'(ANG_LO))
				r = longint'(ANG_LO);
			if (r > longint'(ANG_HI))
				r = longint'(ANG_HI);
			return r[ANG_W-1:0];
		endfunction

		function void push_sample(logic [JNT_W-1:0] jnt, longint idx,
				logic signed [ANG_W-1:0] ang, logic lst);
			sample_t e;
			e.joint = jnt;
			e.idx = idx[IDX_W-1:0];
			e.angle = ang;
			e.last = lst;
			pending_q.push_back(e);
		endfunction

		// Expands one accepted move command into its samples.
		function void note_move(logic act, logic [JNT_W-1:0] jnt,
				logic signed [ANG_W-1:0] a0_in, logic signed [ANG_W-1:0] am_in,
				logic signed [ANG_W-1:0] a1_in);
			longint s, t, den, p, q, a, b, a0, am, a1, d, num;
			s = steps;
			a0 = a0_in;
			am = am_in;
			a1 = a1_in;
			d = a1 - a0;
			n_moves++;
			if (s < 2)
				s = 2;
			if (s > MAX_STEPS_DEF)
				s = MAX_STEPS_DEF;
			if (act == MODE_TWO_POINT) begin
				den = s * s * s;
				for (longint j = 0; j < s; j++) begin
					p = 3 * j * j * s - 2 * j * j * j;
					push_sample(jnt, j, round_angle(a0, d * p, den), j == s - 1);
				end
			end else begin
				t = s >> 1;
				den = t * t * t * s;
				for (int seg = 0; seg < 2; seg++) begin
					a = seg ? am : a0;
					b = seg ? a1 : am;
					for (longint j = 0; j < t; j++) begin
						p = 3 * j * j * t - 2 * j * j * j;
						q = seg ? j * (t - j) * (t - j) : -(j * j * (t - j));
						num = (b - a) * p * s + d * q * t;
						push_sample(jnt, seg * t + j, round_angle(a, num, den),
							seg * t + j == 2 * t - 1);
					end
				end
			end
		endfunction

		// Compares one emitted sample with the oldest expectation.
		function void check_sample(sample_t got);
			sample_t e;
			n_samples++;
			if (pending_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("ERROR: unexpected sample joint=%0d idx=%0d angle=%0d last=%0b",
						got.joint, got.idx, got.angle, got.last);
				return;
			end
			e = pending_q.pop_front();
			if (got.joint !== e.joint || got.idx !== e.idx || got.angle !== e.angle ||
					got.last !== e.last) begin
				n_errors++;
				if (n_errors <= 10)
					$display("ERROR: sample mismatch expected j=%0d i=%0d a=%0d l=%0b, got j=%0d i=%0d a=%0d l=%0b",
						e.joint, e.idx, e.angle, e.last,
						got.joint, got.idx, got.angle, got.last);
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CNT_W-1:0]        cfg_wdata;
	logic                    start;
	logic                    busy;
	logic                    action;
	logic [JNT_W-1:0]        joint;
	logic signed [ANG_W-1:0] start_angle;
	logic signed [ANG_W-1:0] via_angle;
	logic signed [ANG_W-1:0] end_angle;
	logic                    sample_valid;
	logic [JNT_W-1:0]        joint_out;
	logic [IDX_W-1:0]        sample_index;
	logic signed [ANG_W-1:0] sample_angle;
	logic                    last;

	trajectory_board board;
	int idle_pct;
	int last_progress;
	int stall_cycles;

	cubic_joint_trajectory dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.action(action),
		.joint(joint),
		.start_angle(start_angle),
		.via_angle(via_angle),
		.end_angle(end_angle),
		.sample_valid(sample_valid),
		.joint_out(joint_out),
		.sample_index(sample_index),
		.sample_angle(sample_angle),
		.last(last)
	);

	// Clock generation.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Sample monitor: outputs are taken at the edge that ends their cycle.
	always @(posedge clk) begin
		sample_t got;
		if (arst_n && sample_valid) begin
			got.joint = joint_out;
			got.idx = sample_index;
			got.angle = sample_angle;
			got.last = last;
			board.check_sample(got);
		end
	end

	// Watchdog: ends the run after too many cycles without any transaction.
	always @(negedge clk) begin
		if (board != null && arst_n) begin
			if (board.n_moves + board.n_samples != last_progress) begin
				last_progress = board.n_moves + board.n_samples;
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("ERROR: watchdog expired, %0d samples outstanding",
						board.pending_q.size());
					$display("Test completed with failures");
					$finish;
				end
			end
		end
	end

	// Issues one move command; entered and left at a falling edge.
	task automatic send_move(logic act, logic [JNT_W-1:0] jnt,
			logic signed [ANG_W-1:0] a0, logic signed [ANG_W-1:0] am,
			logic signed [ANG_W-1:0] a1);
		logic was_busy;
		if ($urandom_range(0, 99) < idle_pct)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		start = 1'b1;
		action = act;
		joint = jnt;
		start_angle = a0;
		via_angle = am;
		end_angle = a1;
		forever begin
			was_busy = busy;
			@(posedge clk);
			if (!was_busy) begin
				board.note_move(act, jnt, a0, am, a1);
				break;
			end
			@(negedge clk);
		end
		@(negedge clk);
		start = 1'b0;
	endtask

	// Waits until every expected sample has arrived, then lets the pipeline settle.
	task automatic drain();
		while (board.pending_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes the step count register while the block is idle.
	task automatic write_steps(logic [CNT_W-1:0] value);
		drain();
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		board.steps = value;
	endtask

	function automatic logic signed [ANG_W-1:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return ANG_LO;
			1: return ANG_HI;
			2: return ANG_W'($urandom_range(0, 2000)) - 24'sd1000;
			default: return ANG_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [CNT_W-1:0] step_plan[$];
		int per_phase;
		int sent;
		board = new();
		board.reset_state();
		last_progress = 0;
		stall_cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		action = MODE_TWO_POINT;
		joint = '0;
		start_angle = '0;
		via_angle = '0;
		end_angle = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed moves at the reset step count: extremes, both modes, overshoot.
		send_move(MODE_TWO_POINT, 3'd0, ANG_LO, 24'sd0, ANG_HI);
		send_move(MODE_TWO_POINT, 3'd5, ANG_HI, 24'sd0, ANG_LO);
		send_move(MODE_TWO_POINT, 3'd7, 24'sd0, ANG_HI, 24'sd0);
		send_move(MODE_VIA, 3'd6, ANG_LO, ANG_HI, ANG_LO);
		send_move(MODE_VIA, 3'd1, ANG_HI, ANG_LO, ANG_HI);
		send_move(MODE_VIA, 3'd2, ANG_LO, 24'sd0, ANG_HI);
		send_move(MODE_VIA, 3'd4, -24'sd12345, 24'sd777, 24'sd1000);

		// Smallest counts, clamped values, and an odd count in via mode.
		write_steps(7'd2);
		send_move(MODE_TWO_POINT, 3'd3, ANG_LO, ANG_HI, ANG_HI);
		send_move(MODE_VIA, 3'd3, ANG_HI, ANG_LO, ANG_LO);
		write_steps(7'd0);
		send_move(MODE_TWO_POINT, 3'd1, 24'sd5, 24'sd0, -24'sd5);
		send_move(MODE_VIA, 3'd1, 24'sd5, ANG_HI, -24'sd5);
		write_steps(7'd1);
		send_move(MODE_VIA, 3'd2, ANG_LO, ANG_LO, ANG_HI);
		write_steps(7'd7);
		send_move(MODE_VIA, 3'd0, ANG_LO, ANG_HI, ANG_LO);
		send_move(MODE_TWO_POINT, 3'd0, 24'sd1, 24'sd0, 24'sd2);
		write_steps(7'd127);
		send_move(MODE_TWO_POINT, 3'd7, ANG_HI, 24'sd0, ANG_LO);
		send_move(MODE_VIA, 3'd7, 24'sd0, ANG_LO, 24'sd0);

		// Random moves over a sweep of step counts, mostly small ones.
		step_plan = '{7'd4, 7'd2, 7'd9, 7'd64, 7'd3, 7'd16, 7'd65, 7'd6, 7'd1, 7'd12};
		per_phase = RANDOM_MOVES / step_plan.size();
		sent = 0;
		foreach (step_plan[k]) begin
			write_steps(step_plan[k]);
			for (int n = 0; n < per_phase; n++) begin
				if (sent < RANDOM_MOVES / 3)
					idle_pct = 37;
				else if (sent < 2 * RANDOM_MOVES / 3)
					idle_pct = 77;
				else
					idle_pct = 0;
				// Hold off now and then until the pipeline is empty.
				if (n == per_phase / 2)
					drain();
				send_move(logic'($urandom_range(0, 1)), JNT_W'($urandom_range(0, 7)),
					rand_angle(), rand_angle(), rand_angle());
				sent++;
			end
		end

		drain();
		$display("Covered %0d move commands and %0d samples over step counts 0 to 127,",
			board.n_moves, board.n_samples);
		$display("both modes, angle extremes, saturation and idle start gaps.");
		if (board.n_errors == 0 && board.pending_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d samples missing", board.n_errors,
				board.pending_q.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
